// ===== hdl/tri_rrq_pkg.sv =====
`timescale 1ns / 1ps

package tri_rrq_pkg;

    localparam int COORD_W    = 24;
    localparam int QUAL_FRAC  = 16;
    localparam int QUAL_W     = QUAL_FRAC + 1;
    localparam int AREA_W     = 48;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int SQ_W       = PROD_W - 1;
    localparam int TWICE_W    = SQ_W;
    localparam int CROSS_W    = PROD_W + 1;
    localparam int SR_W       = SQ_W + 1;
    localparam int ROOT_W     = DIFF_W;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int PER_W      = ROOT_W + 2;
    localparam int PA_W       = PER_W + ROOT_W;
    localparam int BC_W       = 2 * ROOT_W;
    localparam int DEN_W      = PA_W + BC_W;
    localparam int NUM_W      = 2 * TWICE_W + 2;
    localparam int TL_W       = 25;
    localparam int TH_W       = TWICE_W - TL_W;
    localparam int PAL_W      = PA_W / 2;
    localparam int PAH_W      = PA_W - PAL_W;
    localparam int BCL_W      = BC_W / 2;
    localparam int BCH_W      = BC_W - BCL_W;

    typedef struct packed {
        logic signed [COORD_W-1:0] ax;
        logic signed [COORD_W-1:0] ay;
        logic signed [COORD_W-1:0] bx;
        logic signed [COORD_W-1:0] by_coord;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
    } item_t;

    typedef struct packed {
        logic [QUAL_W-1:0] quality;
        logic              degenerate;
    } result_t;

endpackage

// ===== hdl/triangle_radius_ratio_quality.sv =====
`timescale 1ns / 1ps

// channel   signals                      word
// input     start, busy, item            three corners, accepted on start && !busy
// result    done, res                    quality and degenerate flag, one-cycle strobe
// config    cfg_we, cfg_data             min_twice_area, written on cfg_we
//
// fully pipelined: one triangle per cycle
// stages: 3 vector/square stages, root load plus 25 one-bit square root stages,
// 4 product stages, range check plus 16 divider stages, and the output register
// busy is always low; the receiver cannot stall, so nothing ever waits
// reset clears the valid bits and loads min_twice_area with 1

module triangle_radius_ratio_quality (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  tri_rrq_pkg::item_t                   item,
    output logic                                 done,
    output tri_rrq_pkg::result_t                 res,
    input  logic                                 cfg_we,
    input  logic [tri_rrq_pkg::AREA_W-1:0]       cfg_data
);

    localparam int SN  = tri_rrq_pkg::SQRT_STEPS;
    localparam int QF  = tri_rrq_pkg::QUAL_FRAC;
    localparam int LATENCY = 3 + (SN + 1) + 4 + (QF + 1) + 1;

    localparam int DW  = tri_rrq_pkg::DIFF_W;
    localparam int PW  = tri_rrq_pkg::PROD_W;
    localparam int SW  = tri_rrq_pkg::SQ_W;
    localparam int TW  = tri_rrq_pkg::TWICE_W;
    localparam int RW  = tri_rrq_pkg::SR_W;
    localparam int EW  = tri_rrq_pkg::ROOT_W;
    localparam int NW  = tri_rrq_pkg::NUM_W;
    localparam int DNW = tri_rrq_pkg::DEN_W;

    logic [tri_rrq_pkg::AREA_W-1:0] min_area_reg;

    assign busy = 1'b0;

    // stage 1: edge vectors
    logic                 v1_reg;
    logic signed [DW-1:0] ux_reg, uy_reg, vx_reg, vy_reg, wx_reg, wy_reg;

    // stage 2: squares and cross terms
    logic                 v2_reg;
    logic signed [PW-1:0] sux_reg, suy_reg, svx_reg, svy_reg, swx_reg, swy_reg;
    logic signed [PW-1:0] c1_reg, c2_reg;

    // stage 3: squared lengths and twice area
    logic                 v3_reg;
    logic [SW-1:0]        qa_reg, qb_reg, qc_reg;
    logic [TW-1:0]        tw3_reg;
    logic signed [tri_rrq_pkg::CROSS_W-1:0] cross_next;

    // square root pipeline
    logic          sv_reg  [0:SN];
    logic [RW-1:0] sn_reg  [0:SN][0:2];
    logic [RW-1:0] sr_reg  [0:SN][0:2];
    logic [TW-1:0] st_reg  [0:SN];

    // product stages
    logic                           p1v_reg, p2v_reg, p3v_reg, p4v_reg;
    logic [tri_rrq_pkg::PER_W-1:0]  per_reg;
    logic [EW-1:0]                  ea_reg, eb_reg, ec_reg;
    logic                           dg1_reg, dg2_reg, dg3_reg, dg4_reg;
    logic [2*tri_rrq_pkg::TL_W-1:0] tll_reg;
    logic [tri_rrq_pkg::TL_W+tri_rrq_pkg::TH_W-1:0] tlh_reg, thl_reg;
    logic [2*tri_rrq_pkg::TH_W-1:0] thh_reg;
    logic [tri_rrq_pkg::PA_W-1:0]   pa_reg;
    logic [tri_rrq_pkg::BC_W-1:0]   bc_reg;
    logic [NW-1:0]                  num2_reg, num3_reg, num4_reg;
    logic [tri_rrq_pkg::PAL_W+tri_rrq_pkg::BCL_W-1:0] dll_reg;
    logic [tri_rrq_pkg::PAL_W+tri_rrq_pkg::BCH_W-1:0] dlh_reg;
    logic [tri_rrq_pkg::PAH_W+tri_rrq_pkg::BCL_W-1:0] dhl_reg;
    logic [tri_rrq_pkg::PAH_W+tri_rrq_pkg::BCH_W-1:0] dhh_reg;
    logic [DNW-1:0]                 den4_reg;
    logic [2*TW-1:0]                tsq_next;
    logic [DNW-1:0]                 den_next;

    // divider pipeline: index 0 is the range check, then one quotient bit a stage
    logic           dv_reg  [0:QF];
    logic           ddg_reg [0:QF];
    logic           dsat_reg[0:QF];
    logic           dz_reg  [0:QF];
    logic [DNW:0]   drem_reg[0:QF];
    logic [DNW-1:0] dden_reg[0:QF];
    logic [QF-1:0]  dq_reg  [0:QF];

    logic                  done_reg;
    tri_rrq_pkg::result_t  res_reg;
    tri_rrq_pkg::result_t  res_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_area_reg <= tri_rrq_pkg::AREA_W'(1);
        end
        else if (cfg_we)
        begin
            min_area_reg <= cfg_data;
        end
    end

    always_comb
    begin
        cross_next = tri_rrq_pkg::CROSS_W'(c1_reg) - tri_rrq_pkg::CROSS_W'(c2_reg);
    end

    always_ff @(posedge clk)
    begin
        ux_reg  <= DW'(item.bx) - DW'(item.ax);
        uy_reg  <= DW'(item.by_coord) - DW'(item.ay);
        vx_reg  <= DW'(item.cx) - DW'(item.ax);
        vy_reg  <= DW'(item.cy) - DW'(item.ay);
        wx_reg  <= DW'(item.cx) - DW'(item.bx);
        wy_reg  <= DW'(item.cy) - DW'(item.by_coord);

        sux_reg <= ux_reg * ux_reg;
        suy_reg <= uy_reg * uy_reg;
        svx_reg <= vx_reg * vx_reg;
        svy_reg <= vy_reg * vy_reg;
        swx_reg <= wx_reg * wx_reg;
        swy_reg <= wy_reg * wy_reg;
        c1_reg  <= ux_reg * vy_reg;
        c2_reg  <= uy_reg * vx_reg;

        // squares are non-negative and below 2^48
        qa_reg  <= SW'(sux_reg[PW-3:0]) + SW'(suy_reg[PW-3:0]);
        qb_reg  <= SW'(swx_reg[PW-3:0]) + SW'(swy_reg[PW-3:0]);
        qc_reg  <= SW'(svx_reg[PW-3:0]) + SW'(svy_reg[PW-3:0]);
        tw3_reg <= cross_next[tri_rrq_pkg::CROSS_W-1] ? TW'(-cross_next) : TW'(cross_next);
    end

    // load of the root pipeline
    always_ff @(posedge clk)
    begin
        sn_reg[0][0] <= RW'(qa_reg);
        sn_reg[0][1] <= RW'(qb_reg);
        sn_reg[0][2] <= RW'(qc_reg);
        sr_reg[0][0] <= '0;
        sr_reg[0][1] <= '0;
        sr_reg[0][2] <= '0;
        st_reg[0]    <= tw3_reg;
    end

    for (genvar s = 0; s < SN; s++)
    begin : g_sqrt
        localparam logic [RW-1:0] BIT = RW'(1) << (2 * (SN - 1 - s));
        for (genvar e = 0; e < 3; e++)
        begin : g_edge
            logic [RW-1:0] trial_next;
            logic [RW-1:0] n_next, r_next;
            always_comb
            begin
                trial_next = sr_reg[s][e] + BIT;
                if (sn_reg[s][e] >= trial_next)
                begin
                    n_next = sn_reg[s][e] - trial_next;
                    r_next = (sr_reg[s][e] >> 1) + BIT;
                end
                else
                begin
                    n_next = sn_reg[s][e];
                    r_next = sr_reg[s][e] >> 1;
                end
            end
            always_ff @(posedge clk)
            begin
                sn_reg[s+1][e] <= n_next;
                sr_reg[s+1][e] <= r_next;
            end
        end
        always_ff @(posedge clk)
        begin
            st_reg[s+1] <= st_reg[s];
        end
    end

    always_comb
    begin
        tsq_next = (2*TW)'(tll_reg)
                 + ((2*TW)'(tlh_reg) << tri_rrq_pkg::TL_W)
                 + ((2*TW)'(thl_reg) << tri_rrq_pkg::TL_W)
                 + ((2*TW)'(thh_reg) << (2 * tri_rrq_pkg::TL_W));
        den_next = DNW'(dll_reg)
                 + (DNW'(dlh_reg) << tri_rrq_pkg::BCL_W)
                 + (DNW'(dhl_reg) << tri_rrq_pkg::PAL_W)
                 + (DNW'(dhh_reg) << (tri_rrq_pkg::PAL_W + tri_rrq_pkg::BCL_W));
    end

    always_ff @(posedge clk)
    begin
        // p1: perimeter, threshold test, partial products of the area square
        ea_reg  <= EW'(sr_reg[SN][0]);
        eb_reg  <= EW'(sr_reg[SN][1]);
        ec_reg  <= EW'(sr_reg[SN][2]);
        per_reg <= tri_rrq_pkg::PER_W'(sr_reg[SN][0]) + tri_rrq_pkg::PER_W'(sr_reg[SN][1])
                 + tri_rrq_pkg::PER_W'(sr_reg[SN][2]);
        dg1_reg <= TW'(min_area_reg) > st_reg[SN];
        tll_reg <= st_reg[SN][tri_rrq_pkg::TL_W-1:0] * st_reg[SN][tri_rrq_pkg::TL_W-1:0];
        tlh_reg <= st_reg[SN][tri_rrq_pkg::TL_W-1:0] * st_reg[SN][TW-1:tri_rrq_pkg::TL_W];
        thl_reg <= st_reg[SN][TW-1:tri_rrq_pkg::TL_W] * st_reg[SN][tri_rrq_pkg::TL_W-1:0];
        thh_reg <= st_reg[SN][TW-1:tri_rrq_pkg::TL_W] * st_reg[SN][TW-1:tri_rrq_pkg::TL_W];

        // p2
        pa_reg   <= per_reg * ea_reg;
        bc_reg   <= eb_reg * ec_reg;
        num2_reg <= {tsq_next, 2'b00};
        dg2_reg  <= dg1_reg;

        // p3: partial products of the denominator
        dll_reg  <= pa_reg[tri_rrq_pkg::PAL_W-1:0] * bc_reg[tri_rrq_pkg::BCL_W-1:0];
        dlh_reg  <= pa_reg[tri_rrq_pkg::PAL_W-1:0]
                  * bc_reg[tri_rrq_pkg::BC_W-1:tri_rrq_pkg::BCL_W];
        dhl_reg  <= pa_reg[tri_rrq_pkg::PA_W-1:tri_rrq_pkg::PAL_W]
                  * bc_reg[tri_rrq_pkg::BCL_W-1:0];
        dhh_reg  <= pa_reg[tri_rrq_pkg::PA_W-1:tri_rrq_pkg::PAL_W]
                  * bc_reg[tri_rrq_pkg::BC_W-1:tri_rrq_pkg::BCL_W];
        num3_reg <= num2_reg;
        dg3_reg  <= dg2_reg;

        // p4
        den4_reg <= den_next;
        num4_reg <= num3_reg;
        dg4_reg  <= dg3_reg;

        // range check: quotient of one or more saturates, zero denominator gives zero
        dden_reg[0] <= den4_reg;
        drem_reg[0] <= (DNW+1)'(num4_reg);
        dsat_reg[0] <= (DNW+1)'(num4_reg) >= (DNW+1)'(den4_reg);
        dz_reg[0]   <= den4_reg == '0;
        ddg_reg[0]  <= dg4_reg;
        dq_reg[0]   <= '0;
    end

    for (genvar k = 0; k < QF; k++)
    begin : g_div
        logic [DNW:0] sh_next;
        logic         ge_next;
        always_comb
        begin
            sh_next = {drem_reg[k][DNW-1:0], 1'b0};
            ge_next = sh_next >= (DNW+1)'(dden_reg[k]);
        end
        always_ff @(posedge clk)
        begin
            drem_reg[k+1] <= ge_next ? sh_next - (DNW+1)'(dden_reg[k]) : sh_next;
            dq_reg[k+1]   <= {dq_reg[k][QF-2:0], ge_next};
            dden_reg[k+1] <= dden_reg[k];
            dsat_reg[k+1] <= dsat_reg[k];
            dz_reg[k+1]   <= dz_reg[k];
            ddg_reg[k+1]  <= ddg_reg[k];
        end
    end

    always_comb
    begin
        res_next.degenerate = ddg_reg[QF];
        if (ddg_reg[QF] || dz_reg[QF])
        begin
            res_next.quality = '0;
        end
        else if (dsat_reg[QF])
        begin
            res_next.quality = tri_rrq_pkg::QUAL_W'(1) << QF;
        end
        else
        begin
            res_next.quality = tri_rrq_pkg::QUAL_W'(dq_reg[QF]);
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    // valid bits travel alongside the words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            p1v_reg  <= 1'b0;
            p2v_reg  <= 1'b0;
            p3v_reg  <= 1'b0;
            p4v_reg  <= 1'b0;
            done_reg <= 1'b0;
            for (int i = 0; i <= SN; i++)
            begin
                sv_reg[i] <= 1'b0;
            end
            for (int i = 0; i <= QF; i++)
            begin
                dv_reg[i] <= 1'b0;
            end
        end
        else
        begin
            v1_reg    <= start && !busy;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            sv_reg[0] <= v3_reg;
            for (int i = 0; i < SN; i++)
            begin
                sv_reg[i+1] <= sv_reg[i];
            end
            p1v_reg   <= sv_reg[SN];
            p2v_reg   <= p1v_reg;
            p3v_reg   <= p2v_reg;
            p4v_reg   <= p3v_reg;
            dv_reg[0] <= p4v_reg;
            for (int i = 0; i < QF; i++)
            begin
                dv_reg[i+1] <= dv_reg[i];
            end
            done_reg  <= dv_reg[QF];
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("result strobe missing after accepted word");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LATENCY))
        else $error("result strobe without accepted word");

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && res.degenerate) |-> (res.quality == '0))
        else $error("degenerate result with nonzero quality");

    a_quality_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (res.quality <= (tri_rrq_pkg::QUAL_W'(1) << QF)))
        else $error("quality above one");

endmodule

// ===== sim/tri_rrq_checker.sv =====
`timescale 1ns / 1ps

module tri_rrq_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic                           busy,
    input  tri_rrq_pkg::item_t             item,
    input  logic                           done,
    input  tri_rrq_pkg::result_t           res,
    input  logic                           cfg_we,
    input  logic [tri_rrq_pkg::AREA_W-1:0] cfg_data,
    output int                             failures,
    output int                             pending,
    output int                             words_checked,
    output int                             degenerate_seen,
    output int                             saturated_seen
);

    logic [tri_rrq_pkg::AREA_W-1:0] area_floor;
    tri_rrq_pkg::result_t           quality_q[$];

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= root + bitv)
            begin
                n    = n - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic longint unsigned edge_length(longint dx, longint dy);
        return int_sqrt(longint'(dx * dx) + longint'(dy * dy));
    endfunction

    function automatic tri_rrq_pkg::result_t predict_quality(
        tri_rrq_pkg::item_t t, logic [tri_rrq_pkg::AREA_W-1:0] floor_v);
        tri_rrq_pkg::result_t r;
        longint               ux, uy, vx, vy, cr;
        longint unsigned      twice, ea, eb, ec, per;
        logic [127:0]         num, den, quo;
        ux = longint'(t.bx) - longint'(t.ax);
        uy = longint'(t.by_coord) - longint'(t.ay);
        vx = longint'(t.cx) - longint'(t.ax);
        vy = longint'(t.cy) - longint'(t.ay);
        cr = ux * vy - uy * vx;
        twice = (cr < 0) ? longint'(-cr) : cr;
        r.quality    = '0;
        r.degenerate = 1'b0;
        if (twice < 64'(floor_v))
        begin
            r.degenerate = 1'b1;
            return r;
        end
        ea  = edge_length(ux, uy);
        eb  = edge_length(longint'(t.cx) - longint'(t.bx),
                          longint'(t.cy) - longint'(t.by_coord));
        ec  = edge_length(vx, vy);
        per = ea + eb + ec;
        den = 128'(per * ea) * 128'(eb * ec);
        if (den != 0)
        begin
            num = (128'(twice) * 128'(twice)) << (2 + tri_rrq_pkg::QUAL_FRAC);
            if (num >= (den << tri_rrq_pkg::QUAL_FRAC))
                r.quality = tri_rrq_pkg::QUAL_W'(1) << tri_rrq_pkg::QUAL_FRAC;
            else
            begin
                quo       = num / den;
                r.quality = quo[tri_rrq_pkg::QUAL_W-1:0];
            end
        end
        return r;
    endfunction

    assign pending = quality_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            area_floor = 48'd1;
            quality_q.delete();
            failures        = 0;
            words_checked   = 0;
            degenerate_seen = 0;
            saturated_seen  = 0;
        end
        else
        begin
            if (cfg_we)
                area_floor = cfg_data;
            // append the prediction at the tail of the queue
            if (start && !busy)
                quality_q = {quality_q, predict_quality(item, area_floor)};
            if (done)
            begin
                if (quality_q.size() == 0)
                begin
                    $error("result word with nothing expected: quality %0d degenerate %0d",
                           res.quality, res.degenerate);
                    failures++;
                end
                else
                begin
                    tri_rrq_pkg::result_t want;
                    want = quality_q.pop_front();
                    words_checked++;
                    if (want.degenerate)
                        degenerate_seen++;
                    if (want.quality == (tri_rrq_pkg::QUAL_W'(1) << tri_rrq_pkg::QUAL_FRAC))
                        saturated_seen++;
                    if (res.quality !== want.quality)
                    begin
                        $error("quality: expected %0d, got %0d", want.quality, res.quality);
                        failures++;
                    end
                    if (res.degenerate !== want.degenerate)
                    begin
                        $error("degenerate: expected %0d, got %0d",
                               want.degenerate, res.degenerate);
                        failures++;
                    end
                end
            end
        end
    end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;

    localparam int LATENCY     = 51;
    localparam int CYCLE_LIMIT = 200000;

    logic                           clk;
    logic                           rst_n;
    logic                           start;
    logic                           busy;
    tri_rrq_pkg::item_t             item;
    logic                           done;
    tri_rrq_pkg::result_t           res;
    logic                           cfg_we;
    logic [tri_rrq_pkg::AREA_W-1:0] cfg_data;
    int                failures, pending, words_checked, degenerate_seen, saturated_seen;
    int                idle_pct;
    int                cycles;
    int                thresholds_used;

    triangle_radius_ratio_quality dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .item     (item),
        .done     (done),
        .res      (res),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    tri_rrq_checker chk (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .item            (item),
        .done            (done),
        .res             (res),
        .cfg_we          (cfg_we),
        .cfg_data        (cfg_data),
        .failures        (failures),
        .pending         (pending),
        .words_checked   (words_checked),
        .degenerate_seen (degenerate_seen),
        .saturated_seen  (saturated_seen)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_triangle(input tri_rrq_pkg::item_t t);
        while ($urandom_range(99, 0) < idle_pct)
        begin
            start <= 1'b0;
            item  <= tri_rrq_pkg::item_t'({$urandom, $urandom, $urandom, $urandom,
                                           16'($urandom)});
            @(posedge clk);
        end
        start <= 1'b1;
        item  <= t;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic send_corners(input int ax, ay, bx, by, cx, cy);
        tri_rrq_pkg::item_t t;
        t.ax = ax[23:0]; t.ay = ay[23:0];
        t.bx = bx[23:0]; t.by_coord = by[23:0];
        t.cx = cx[23:0]; t.cy = cy[23:0];
        send_triangle(t);
    endtask

    // drain the pipeline, then load a new threshold
    task automatic set_area_floor(input logic [tri_rrq_pkg::AREA_W-1:0] v);
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
        thresholds_used++;
    endtask

    task automatic directed_set();
        send_corners(0, 0, 0, 0, 0, 0);                       // all corners coincide
        send_corners(65536, 65536, 65536, 65536, 0, 0);       // two corners coincide
        send_corners(0, 0, 65536, 65536, 131072, 131072);     // collinear
        send_corners(0, 0, 1, 0, 0, 1);                       // smallest right triangle
        send_corners(0, 0, 2, 0, 1, 1);
        send_corners(0, 0, 65536, 0, 32768, 56756);           // near equilateral
        send_corners(0, 0, 131072, 0, 65536, 113512);         // truncation may saturate
        send_corners(-8388608, -8388608, 8388607, -8388608, 0, 8388607);
        send_corners(-8388608, -8388608, 8388607, 8388607, -8388608, 8388607);
        send_corners(8388607, 8388607, -8388608, 8388607, 8388607, -8388608);
        send_corners(-8388608, 0, 8388607, 0, 0, 1);          // long sliver
        send_corners(-8388608, -8388608, 8388607, 8388607, 8388607, 8388606);
        send_corners(100, 200, 300, 50, -400, 1000);
        send_corners(-1, -1, -1, -1, -1, -1);
        send_corners(8388607, 8388607, 8388607, 8388607, 8388607, 8388607);
    endtask

    task automatic random_triangle();
        int ax, ay, k, span;
        ax   = int'($urandom);
        ay   = int'($urandom);
        k    = $urandom_range(23, 1);
        span = 1 << k;
        case ($urandom_range(9, 0))
            0, 1:
                send_corners(int'($urandom), int'($urandom), int'($urandom),
                             int'($urandom), int'($urandom), int'($urandom));
            2:
            begin
                // collinear or nearly so
                int dx, dy, m;
                dx = $urandom_range(span, 0) - span / 2;
                dy = $urandom_range(span, 0) - span / 2;
                m  = $urandom_range(3, 0) - 1;
                send_corners(ax, ay, ax + dx, ay + dy, ax + m * dx + $urandom_range(1, 0),
                             ay + m * dy);
            end
            3:
                send_corners(ax, ay, ax, ay, ax + $urandom_range(span, 0), ay);
            default:
                send_corners(ax, ay,
                             ax + $urandom_range(span, 0) - span / 2,
                             ay + $urandom_range(span, 0) - span / 2,
                             ax + $urandom_range(span, 0) - span / 2,
                             ay + $urandom_range(span, 0) - span / 2);
        endcase
    endtask

    initial
    begin
        rst_n    = 1'b0;
        start    = 1'b0;
        item     = '0;
        cfg_we   = 1'b0;
        cfg_data = '0;
        cycles   = 0;
        idle_pct = 32;
        thresholds_used = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_set();                 // reset threshold of one
        set_area_floor('0);
        directed_set();
        set_area_floor({tri_rrq_pkg::AREA_W{1'b1}});
        directed_set();

        for (int phase = 0; phase < 3; phase++)
        begin
            idle_pct = (phase == 0) ? 32 : ((phase == 1) ? 50 : 0);
            set_area_floor(48'(1) << $urandom_range(40, 0));
            for (int i = 0; i < 500; i++)
            begin
                if (i == 250)
                    set_area_floor(tri_rrq_pkg::AREA_W'({$urandom, $urandom}));
                random_triangle();
            end
        end

        start <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);

        $display("checked %0d result words over %0d thresholds, idle and back-to-back",
                 words_checked, thresholds_used);
        $display("degenerate words %0d, saturated quality words %0d",
                 degenerate_seen, saturated_seen);
        if (failures == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
